>>> hw/rtl/token_lexer_fsm_unit_assert.svh
// Assertion macros used by the checker of the token lexer.
`ifndef TOKEN_LEXER_FSM_UNIT_ASSERT_SVH
`define TOKEN_LEXER_FSM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token lexer: property violated");

// The consequent must hold in the cycle after the antecedent.
`define TLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token lexer: property violated");

`endif

>>> hw/rtl/tlf_pkg.sv
// Package of the token lexer: scanner states, token kinds, keyword tables and shared types.
package tlf_pkg;

    typedef enum logic [2:0] {
        ST_START   = 3'd0,
        ST_IDENT   = 3'd1,
        ST_INT     = 3'd2,
        ST_DOT     = 3'd3,
        ST_REAL    = 3'd4,
        ST_COLON   = 3'd5,
        ST_LESS    = 3'd6,
        ST_GREATER = 3'd7
    } scan_state_t;

    typedef logic [5:0] kind_t;

    localparam kind_t K_EOF     = 6'd0;
    localparam kind_t K_ERROR   = 6'd1;
    localparam kind_t K_IDENT   = 6'd2;
    localparam kind_t K_INT     = 6'd3;
    localparam kind_t K_REAL    = 6'd4;
    localparam kind_t K_KW_BASE = 6'd5;
    localparam kind_t K_ASSIGN  = 6'd17;
    localparam kind_t K_EQ      = 6'd18;
    localparam kind_t K_LT      = 6'd19;
    localparam kind_t K_LE      = 6'd20;
    localparam kind_t K_NE      = 6'd21;
    localparam kind_t K_GT      = 6'd22;
    localparam kind_t K_GE      = 6'd23;
    localparam kind_t K_PLUS    = 6'd24;
    localparam kind_t K_MINUS   = 6'd25;
    localparam kind_t K_STAR    = 6'd26;
    localparam kind_t K_SLASH   = 6'd27;
    localparam kind_t K_LPAREN  = 6'd28;
    localparam kind_t K_RPAREN  = 6'd29;
    localparam kind_t K_LBRACK  = 6'd30;
    localparam kind_t K_RBRACK  = 6'd31;
    localparam kind_t K_SEMI    = 6'd32;

    localparam int KW_COUNT = 12;
    localparam int KIND_BITS = 6;

    // Keyword text is right-aligned: the last character sits in the lowest byte.
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        40'("begin"), 40'("end"), 40'("if"), 40'("then"), 40'("else"), 40'("while"),
        40'("do"), 40'("read"), 40'("write"), 40'("sqrt"), 40'("exp"), 40'("log")
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 3, 2, 4, 4, 5, 2, 4, 5, 4, 3, 3};

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic [7:0] kw_char_at(input int k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(pos) < KW_LEN[k])
        begin
            ch = KW_TEXT[k][8 * (KW_LEN[k] - 1 - int'(pos)) +: 8];
        end
        return ch;
    endfunction

endpackage

>>> hw/rtl/tlf_scanner.sv
// Scanner state machine of the token lexer: consumes one byte and yields up to two tokens.
module tlf_scanner #(
    parameter int LINE_BITS = 16,
    parameter int COL_BITS  = 12,
    parameter int LEN_BITS  = 8,
    localparam int TOK_W    = 6 + LINE_BITS + COL_BITS + LEN_BITS + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [7:0]         char_byte,
    input  logic               end_of_input,
    output tlf_pkg::push_t     push,
    output logic [TOK_W-1:0]   tok0,
    output logic [TOK_W-1:0]   tok1
);
    import tlf_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
    localparam logic [KW_COUNT-1:0]  CAND_ALL = {KW_COUNT{1'b1}};

    scan_state_t          state_reg, state_next;
    logic [COL_BITS-1:0]  start_col_reg, start_col_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [KW_COUNT-1:0]  cand_reg, cand_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [COL_BITS-1:0]  col_reg, col_next;

    logic                 is_end, c_alpha, c_digit, c_space, is_single;
    logic                 used, done, cont;
    kind_t                done_kind, pend_kind, kw_kind, single_kind;
    scan_state_t          open_state;
    logic [LEN_BITS-1:0]  len_inc;
    logic [KW_COUNT-1:0]  cand_cont, cand_fresh;

    logic                 a_valid, b_valid;
    kind_t                a_kind, b_kind;
    logic [COL_BITS-1:0]  a_col, b_col;
    logic [LEN_BITS-1:0]  a_len, b_len;

    assign is_end  = end_of_input || (char_byte == 8'h00);
    assign c_alpha = (char_byte >= "a" && char_byte <= "z") ||
                     (char_byte >= "A" && char_byte <= "Z");
    assign c_digit = char_byte >= "0" && char_byte <= "9";
    assign c_space = (char_byte == " ") || (char_byte >= 8'd9 && char_byte <= 8'd13);
    assign len_inc = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            cand_cont[k]  = cand_reg[k] && (len_reg < LEN_BITS'(KW_LEN[k])) &&
                            (kw_char_at(k, len_reg[2:0]) == char_byte);
            cand_fresh[k] = kw_char_at(k, 3'd0) == char_byte;
        end
    end

    always_comb
    begin
        kw_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (len_reg == LEN_BITS'(KW_LEN[k])))
            begin
                kw_kind = K_KW_BASE + KIND_BITS'(k);
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDENT:   pend_kind = kw_kind;
            ST_INT:     pend_kind = K_INT;
            ST_REAL:    pend_kind = K_REAL;
            ST_LESS:    pend_kind = K_LT;
            ST_GREATER: pend_kind = K_GT;
            default:    pend_kind = K_ERROR;
        endcase
    end

    always_comb
    begin
        used      = 1'b0;
        done      = 1'b0;
        done_kind = K_ERROR;
        case (state_reg)
            ST_IDENT:   used = c_alpha || c_digit;
            ST_INT:     used = c_digit || (char_byte == ".");
            ST_DOT:     used = c_digit;
            ST_REAL:    used = c_digit;
            ST_COLON:
            begin
                used      = char_byte == "=";
                done      = used;
                done_kind = K_ASSIGN;
            end
            ST_LESS:
            begin
                used      = (char_byte == "=") || (char_byte == ">");
                done      = used;
                done_kind = (char_byte == "=") ? K_LE : K_NE;
            end
            ST_GREATER:
            begin
                used      = char_byte == "=";
                done      = used;
                done_kind = K_GE;
            end
            default:    used = 1'b0;
        endcase
    end

    assign cont = (state_reg != ST_START) && used;

    always_comb
    begin
        is_single  = 1'b0;
        open_state = ST_START;
        if (c_alpha)
        begin
            open_state = ST_IDENT;
        end
        else if (c_digit)
        begin
            open_state = ST_INT;
        end
        else if (char_byte == ":")
        begin
            open_state = ST_COLON;
        end
        else if (char_byte == "<")
        begin
            open_state = ST_LESS;
        end
        else if (char_byte == ">")
        begin
            open_state = ST_GREATER;
        end
        else
        begin
            is_single = !c_space;
        end
    end

    always_comb
    begin
        case (char_byte)
            "=":     single_kind = K_EQ;
            "+":     single_kind = K_PLUS;
            "-":     single_kind = K_MINUS;
            "*":     single_kind = K_STAR;
            "/":     single_kind = K_SLASH;
            "(":     single_kind = K_LPAREN;
            ")":     single_kind = K_RPAREN;
            "[":     single_kind = K_LBRACK;
            "]":     single_kind = K_RBRACK;
            ";":     single_kind = K_SEMI;
            default: single_kind = K_ERROR;
        endcase
    end

    // Next state of the scanner and its position counters.
    always_comb
    begin
        state_next     = state_reg;
        start_col_next = start_col_reg;
        len_next       = len_reg;
        cand_next      = cand_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        if (in_fire)
        begin
            if (is_end)
            begin
                state_next = ST_START;
                len_next   = '0;
                cand_next  = CAND_ALL;
            end
            else
            begin
                if (cont)
                begin
                    if (done)
                    begin
                        state_next = ST_START;
                        len_next   = '0;
                        cand_next  = CAND_ALL;
                    end
                    else
                    begin
                        len_next  = len_inc;
                        cand_next = cand_cont;
                        if (state_reg == ST_INT && char_byte == ".")
                        begin
                            state_next = ST_DOT;
                        end
                        else if (state_reg == ST_DOT)
                        begin
                            state_next = ST_REAL;
                        end
                    end
                end
                else if (c_space || is_single)
                begin
                    state_next = ST_START;
                    len_next   = '0;
                    cand_next  = CAND_ALL;
                    if (is_single)
                    begin
                        start_col_next = col_reg;
                    end
                end
                else
                begin
                    state_next     = open_state;
                    start_col_next = col_reg;
                    len_next       = LEN_BITS'(1);
                    cand_next      = cand_fresh;
                end
                if (char_byte == 8'h0A)
                begin
                    line_next = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
                    col_next  = COL_BITS'(1);
                end
                else
                begin
                    col_next = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;
                end
            end
        end
    end

    // Tokens caused by the current byte, in the order they are delivered.
    always_comb
    begin
        a_valid = 1'b0;
        a_kind  = pend_kind;
        a_col   = start_col_reg;
        a_len   = len_reg;
        b_valid = 1'b0;
        b_kind  = single_kind;
        b_col   = col_reg;
        b_len   = LEN_BITS'(1);
        if (is_end)
        begin
            a_valid = state_reg != ST_START;
            b_valid = 1'b1;
            b_kind  = K_EOF;
            b_len   = '0;
        end
        else if (cont)
        begin
            a_valid = done;
            a_kind  = done_kind;
            a_len   = len_inc;
        end
        else
        begin
            a_valid = state_reg != ST_START;
            b_valid = is_single;
        end
    end

    assign push.first  = in_fire && (a_valid || b_valid);
    assign push.second = in_fire && a_valid && b_valid;
    assign tok1 = {1'b1, b_len, b_col, line_reg, b_kind};
    assign tok0 = a_valid ? {!b_valid, a_len, a_col, line_reg, a_kind} : tok1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            start_col_reg <= COL_BITS'(1);
            len_reg       <= '0;
            cand_reg      <= CAND_ALL;
            line_reg      <= LINE_BITS'(1);
            col_reg       <= COL_BITS'(1);
        end
        else
        begin
            state_reg     <= state_next;
            start_col_reg <= start_col_next;
            len_reg       <= len_next;
            cand_reg      <= cand_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
        end
    end

endmodule

>>> hw/rtl/tlf_token_fifo.sv
// Four-entry token queue that takes one or two tokens per cycle and delivers one when out_ready is high.
module tlf_token_fifo #(
    parameter int WIDTH = 44
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tlf_pkg::push_t   push,
    input  logic [WIDTH-1:0] d0,
    input  logic [WIDTH-1:0] d1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import tlf_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room      = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.first) + PTR_W'(push.second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_ptr_reg] <= d0;
        end
        if (push.second)
        begin
            mem_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/token_lexer_fsm_unit.sv
// Top level of the token lexer: a byte stream in, a token stream out.
// The slave channel carries one source byte per transfer in s_tdata; s_tlast marks the
// end of the source, and a zero byte acts the same way. The master channel carries one
// token per transfer: kind, line, start column and saturating length in m_tdata, and
// m_tlast on the final token caused by one input transfer.
// A byte is scanned in the cycle it is taken, and its tokens are written to a four-entry
// queue whose head drives the master channel, so each token is registered in the queue
// before it reaches the master channel.
// Throughput is one byte per cycle while the receiver keeps up; a byte that yields two
// tokens needs two master transfers, set by the single-token output port of the queue.
// s_tready is high while the queue has room for two tokens, so it does not
// depend on m_tready in the same cycle; when the receiver stalls, the queue fills and
// the byte stream is held until room returns.
// Reset puts the scanner in its start state at line 1, column 1 and empties the queue.
module token_lexer_fsm_unit #(
    parameter int LINE_BITS = 16,
    parameter int COL_BITS  = 12,
    parameter int LEN_BITS  = 8,
    localparam int DATA_W   = ((6 + LINE_BITS + COL_BITS + LEN_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // char_byte
    input  logic              s_tlast,   // end_of_input
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // token_kind, token_line, token_column, token_length
    output logic              m_tlast    // last_of_run
);
    import tlf_pkg::*;

    localparam int TOK_W = 6 + LINE_BITS + COL_BITS + LEN_BITS + 1;

    push_t            push;
    logic             in_fire;
    logic [TOK_W-1:0] tok0, tok1, head;

    assign in_fire = s_tvalid && s_tready;

    tlf_scanner #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .char_byte    (s_tdata),
        .end_of_input (s_tlast),
        .push         (push),
        .tok0         (tok0),
        .tok1         (tok1)
    );

    tlf_token_fifo #(
        .WIDTH (TOK_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .d0        (tok0),
        .d1        (tok1),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = DATA_W'(head[TOK_W-2:0]);
    assign m_tlast = head[TOK_W-1];

endmodule

>>> hw/rtl/tlf_checker.sv
// Port-level checker of the token lexer and its binding to the top level.
`include "token_lexer_fsm_unit_assert.svh"

module tlf_checker #(
    parameter int LINE_BITS = 16,
    parameter int COL_BITS  = 12,
    parameter int LEN_BITS  = 8,
    localparam int DATA_W   = ((6 + LINE_BITS + COL_BITS + LEN_BITS + 7) / 8) * 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [7:0]        s_tdata,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast
);
    import tlf_pkg::*;

    localparam int LEN_LSB = 6 + LINE_BITS + COL_BITS;

    logic                eoi_fire;
    logic                stall;
    logic                eof_head;
    logic [LEN_BITS-1:0] m_len;
    logic [DATA_W:0]     m_beat;

    assign eoi_fire = s_tvalid && s_tready && (s_tlast || s_tdata == 8'h00);
    assign stall    = m_tvalid && !m_tready;
    assign eof_head = m_tvalid && (m_tdata[5:0] == K_EOF);
    assign m_len    = m_tdata[LEN_LSB +: LEN_BITS];
    assign m_beat   = {m_tlast, m_tdata};

    `TLF_ASSERT_NEXT(a_stall_hold, clk, rst_n, stall, m_tvalid && $stable(m_beat))
    `TLF_ASSERT_SAME(a_eof_last, clk, rst_n, eof_head, m_tlast && (m_len == '0))
    `TLF_ASSERT_SAME(a_kind_range, clk, rst_n, m_tvalid, m_tdata[5:0] <= K_SEMI)
    `TLF_ASSERT_SAME(a_empty_ready, clk, rst_n, !m_tvalid, s_tready)
    `TLF_ASSERT_NEXT(a_eof_next, clk, rst_n, eoi_fire, m_tvalid)

endmodule

bind token_lexer_fsm_unit tlf_checker #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS),
    .LEN_BITS  (LEN_BITS)
) u_tlf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
